/* rtl/core/tilt_pkg.sv */
package tilt_pkg;

   // angle fraction and derived widths
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int CORDIC_ITERS    = ANGLE_FRAC_BITS + 6;
   localparam int MAG_FRAC        = 16;
   localparam int ROOT_STEPS      = 32;
   localparam int XW              = 36;                  // cordic x/y width
   localparam int ZW              = ANGLE_FRAC_BITS + 9; // cordic angle width

   localparam longint unsigned E9             = 64'd1000000000;
   localparam longint unsigned DEG_PER_RAD_E9 = 64'd57295779513;

   localparam longint unsigned ATAN_DEG_E9 [12] = '{
      64'd45000000000, 64'd26565051177, 64'd14036243468, 64'd7125016349,
      64'd3576334375,  64'd1789910608,  64'd895173710,   64'd447614171,
      64'd223810500,   64'd111905677,   64'd55952892,    64'd27976453
   };

   // side data riding with a lane through the root pipeline
   typedef struct packed {
      logic signed [15:0] num;
      logic               all_zero;
   } side_type;

   // flags riding through the cordic
   typedef struct packed {
      logic num_zero;
      logic all_zero;
   } flag_type;

   typedef struct packed {
      logic signed [7:0] pitch_deg;
      logic              pitch_valid;
      logic signed [7:0] roll_deg;
   } result_type;

   // round(d * 2^s / 1e9), evaluated at elaboration only
   function automatic longint unsigned e9_to_fixed(longint unsigned d, int s);
      longint unsigned q;
      longint unsigned r;
      q = d / E9;
      r = d % E9;
      return (q << s) + (((r << s) + E9 / 2) / E9);
   endfunction

   // atan(2^-i) in degrees, ANGLE_FRAC_BITS fraction bits
   function automatic longint unsigned angle_step(int i);
      longint unsigned w;
      w = e9_to_fixed(DEG_PER_RAD_E9, ANGLE_FRAC_BITS + 8);
      if (i < 12) begin
         return e9_to_fixed(ATAN_DEG_E9[i], ANGLE_FRAC_BITS);
      end
      return (w + (64'd1 << (i + 7))) >> (i + 8);
   endfunction

endpackage

/* rtl/core/tilt_if.sv */
interface tilt_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;

   modport source (output valid, accel_x, accel_y, accel_z, input ready);
   modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface tilt_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] pitch_deg;
   logic              pitch_valid;
   logic signed [7:0] roll_deg;

   modport source (output valid, pitch_deg, pitch_valid, roll_deg, input ready);
   modport sink   (input valid, pitch_deg, pitch_valid, roll_deg, output ready);
endinterface

/* rtl/core/tilt_angle_from_acceleration_core.sv */
// Channel | Dir | Transfer            | Payload
// req     | in  | valid & ready       | accel_x, accel_y, accel_z (s16)
// rsp     | out | valid & ready       | pitch_deg (s8), pitch_valid, roll_deg (s8)
//
// One sample per cycle sustained while the skid slot stays empty; 2 + 32 + 22 + 1 + 1
// = 58 register stages, among them the 32 square-root stages and
// ANGLE_FRAC_BITS + 6 CORDIC stages.
// Synchronous reset clears the valid bits only; payload registers are not reset.
// Stalls freeze the whole pipeline only once the output skid slot is full, so
// one more transfer is taken while a result waits; nothing is lost or repeated.
module tilt_angle_from_acceleration_core
   import tilt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   tilt_req_if.sink    req,
   tilt_rsp_if.source  rsp
);

   localparam logic signed [ZW-1:0] LIM = ZW'(90) <<< ANGLE_FRAC_BITS;

   // clamp to +-90 deg, truncate toward zero
   function automatic logic signed [7:0] to_deg(logic signed [ZW-1:0] z, logic num_zero);
      logic signed [ZW-1:0] zc;
      logic signed [ZW-1:0] q;
      zc = z;
      if (z > LIM) begin
         zc = LIM;
      end else if (z < -LIM) begin
         zc = -LIM;
      end
      if (zc >= 0) begin
         q = zc >>> ANGLE_FRAC_BITS;
      end else begin
         q = -((-zc) >>> ANGLE_FRAC_BITS);
      end
      return num_zero ? 8'sd0 : q[7:0];
   endfunction

   logic en;   // pipeline advance, held off only by a full skid slot

   // stage 1: squares
   logic               s1_v_ff;
   logic [31:0]        xx_ff, yy_ff, zz_ff;
   logic signed [15:0] s1_ax_ff, s1_ay_ff;
   logic               s1_zero_ff;

   // stage 2: sums of squares
   logic               s2_v_ff;
   logic [31:0]        sq_p_ff, sq_r_ff;
   side_type           side_p_ff, side_r_ff;

   // root and cordic lanes
   logic               rp_v, rr_v;
   logic [31:0]        root_p, root_r;
   side_type           rside_p, rside_r;
   logic               cp_v, cr_v;
   logic signed [ZW-1:0] ang_p, ang_r;
   flag_type           fl_p, fl_r;

   // final stage, output register and skid slot
   logic               fin_v_ff;
   result_type         fin_ff, fin_in;
   logic               out_v_ff, sk_v_ff;
   result_type         out_ff, sk_ff;
   logic               take;

   assign en        = !sk_v_ff;
   assign req.ready = en;
   assign take      = rsp.valid && rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req.valid;
         s2_v_ff <= s1_v_ff;
      end
      if (en) begin
         xx_ff      <= 32'(req.accel_x * req.accel_x);
         yy_ff      <= 32'(req.accel_y * req.accel_y);
         zz_ff      <= 32'(req.accel_z * req.accel_z);
         s1_ax_ff   <= req.accel_x;
         s1_ay_ff   <= req.accel_y;
         s1_zero_ff <= (req.accel_x == 16'sd0) && (req.accel_y == 16'sd0)
                       && (req.accel_z == 16'sd0);
         // pitch uses y over |x,z|, roll uses x over |y,z|
         sq_p_ff    <= xx_ff + zz_ff;
         sq_r_ff    <= yy_ff + zz_ff;
         side_p_ff  <= '{num: s1_ay_ff, all_zero: s1_zero_ff};
         side_r_ff  <= '{num: s1_ax_ff, all_zero: s1_zero_ff};
      end
   end

   tilt_isqrt u_isqrt_p (
      .clock, .reset, .en,
      .in_valid (s2_v_ff), .in_sq (sq_p_ff), .in_side (side_p_ff),
      .out_valid (rp_v), .out_root (root_p), .out_side (rside_p)
   );

   tilt_isqrt u_isqrt_r (
      .clock, .reset, .en,
      .in_valid (s2_v_ff), .in_sq (sq_r_ff), .in_side (side_r_ff),
      .out_valid (rr_v), .out_root (root_r), .out_side (rside_r)
   );

   tilt_cordic u_cordic_p (
      .clock, .reset, .en,
      .in_valid (rp_v), .in_root (root_p), .in_side (rside_p),
      .out_valid (cp_v), .out_angle (ang_p), .out_flags (fl_p)
   );

   tilt_cordic u_cordic_r (
      .clock, .reset, .en,
      .in_valid (rr_v), .in_root (root_r), .in_side (rside_r),
      .out_valid (cr_v), .out_angle (ang_r), .out_flags (fl_r)
   );

   // all-zero sample: both numerators are zero, so both angles come out 0
   always_comb begin
      fin_in.pitch_deg   = to_deg(ang_p, fl_p.num_zero);
      fin_in.roll_deg    = to_deg(ang_r, fl_r.num_zero);
      fin_in.pitch_valid = !(fl_p.all_zero && fl_r.all_zero);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_v_ff <= 1'b0;
         out_v_ff <= 1'b0;
         sk_v_ff  <= 1'b0;
      end else if (sk_v_ff) begin
         // pipeline frozen; drain the skid slot into the output register
         if (take) begin
            out_ff  <= sk_ff;
            sk_v_ff <= 1'b0;
         end
      end else begin
         fin_v_ff <= cp_v;
         fin_ff   <= fin_in;
         if (!out_v_ff || take) begin
            out_v_ff <= fin_v_ff;
            out_ff   <= fin_ff;
         end else if (fin_v_ff) begin
            sk_v_ff <= 1'b1;
            sk_ff   <= fin_ff;
         end
      end
   end

   assign rsp.valid       = out_v_ff;
   assign rsp.pitch_deg   = out_ff.pitch_deg;
   assign rsp.pitch_valid = out_ff.pitch_valid;
   assign rsp.roll_deg    = out_ff.roll_deg;

`ifndef NO_ASSERTIONS
   a_lanes_aligned : assert property (@(posedge clock) disable iff (reset)
      (cp_v == cr_v) && (rp_v == rr_v))
      else $error("pitch and roll lanes out of step");

   a_skid_implies_out : assert property (@(posedge clock) disable iff (reset)
      sk_v_ff |-> out_v_ff)
      else $error("skid slot full with output register empty");

   a_invalid_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.pitch_valid) |-> (rsp.pitch_deg == 8'sd0 && rsp.roll_deg == 8'sd0))
      else $error("all-zero sample gave a non-zero angle");

   a_range : assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> (rsp.pitch_deg >= -8'sd90 && rsp.pitch_deg <= 8'sd90
                     && rsp.roll_deg >= -8'sd90 && rsp.roll_deg <= 8'sd90))
      else $error("angle outside +-90 degrees");
`endif

endmodule

/* rtl/core/tilt_isqrt.sv */
// Floor square root of {sq, 32'b0}, one result bit per stage.
module tilt_isqrt
   import tilt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        en,
   input  logic        in_valid,
   input  logic [31:0] in_sq,
   input  side_type    in_side,
   output logic        out_valid,
   output logic [31:0] out_root,
   output side_type    out_side
);

   logic        stage_v    [ROOT_STEPS+1];
   logic [63:0] stage_rem  [ROOT_STEPS+1];
   logic [63:0] stage_root [ROOT_STEPS+1];
   side_type    stage_side [ROOT_STEPS+1];

   assign stage_v[0]    = in_valid;
   assign stage_rem[0]  = {in_sq, 32'd0};
   assign stage_root[0] = 64'd0;
   assign stage_side[0] = in_side;

   for (genvar s = 0; s < ROOT_STEPS; s++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (2 * (ROOT_STEPS - 1 - s));

      logic        valid_ff;
      logic [63:0] rem_ff,  rem_in;
      logic [63:0] root_ff, root_in;
      side_type    side_ff;
      logic [63:0] trial;

      always_comb begin
         trial = stage_root[s] + BIT;
         if (stage_rem[s] >= trial) begin
            rem_in  = stage_rem[s] - trial;
            root_in = (stage_root[s] >> 1) + BIT;
         end else begin
            rem_in  = stage_rem[s];
            root_in = stage_root[s] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= stage_v[s];
         end
         if (en) begin
            rem_ff  <= rem_in;
            root_ff <= root_in;
            side_ff <= stage_side[s];
         end
      end

      assign stage_v[s+1]    = valid_ff;
      assign stage_rem[s+1]  = rem_ff;
      assign stage_root[s+1] = root_ff;
      assign stage_side[s+1] = side_ff;
   end

   assign out_valid = stage_v[ROOT_STEPS];
   assign out_root  = stage_root[ROOT_STEPS][31:0];
   assign out_side  = stage_side[ROOT_STEPS];

endmodule

/* rtl/core/tilt_cordic.sv */
// Vectoring CORDIC, one rotation per stage, angle in degrees.
module tilt_cordic
   import tilt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic [31:0]          in_root,
   input  side_type             in_side,
   output logic                 out_valid,
   output logic signed [ZW-1:0] out_angle,
   output flag_type             out_flags
);

   logic                 stage_v [CORDIC_ITERS+1];
   logic signed [XW-1:0] stage_x [CORDIC_ITERS+1];
   logic signed [XW-1:0] stage_y [CORDIC_ITERS+1];
   logic signed [ZW-1:0] stage_z [CORDIC_ITERS+1];
   flag_type             stage_f [CORDIC_ITERS+1];

   assign stage_v[0]          = in_valid;
   assign stage_x[0]          = signed'({{(XW-32){1'b0}}, in_root});
   assign stage_y[0]          = XW'(in_side.num) <<< MAG_FRAC;
   assign stage_z[0]          = '0;
   assign stage_f[0].num_zero = (in_side.num == 16'sd0);
   assign stage_f[0].all_zero = in_side.all_zero;

   for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_rot
      localparam logic signed [ZW-1:0] STEP = ZW'(angle_step(i));

      logic                 valid_ff;
      logic signed [XW-1:0] x_ff, x_in;
      logic signed [XW-1:0] y_ff, y_in;
      logic signed [ZW-1:0] z_ff, z_in;
      flag_type             f_ff;

      always_comb begin
         if (stage_y[i] > 0) begin
            x_in = stage_x[i] + (stage_y[i] >>> i);
            y_in = stage_y[i] - (stage_x[i] >>> i);
            z_in = stage_z[i] + STEP;
         end else begin
            x_in = stage_x[i] - (stage_y[i] >>> i);
            y_in = stage_y[i] + (stage_x[i] >>> i);
            z_in = stage_z[i] - STEP;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (en) begin
            valid_ff <= stage_v[i];
         end
         if (en) begin
            x_ff <= x_in;
            y_ff <= y_in;
            z_ff <= z_in;
            f_ff <= stage_f[i];
         end
      end

      assign stage_v[i+1] = valid_ff;
      assign stage_x[i+1] = x_ff;
      assign stage_y[i+1] = y_ff;
      assign stage_z[i+1] = z_ff;
      assign stage_f[i+1] = f_ff;
   end

   assign out_valid = stage_v[CORDIC_ITERS];
   assign out_angle = stage_z[CORDIC_ITERS];
   assign out_flags = stage_f[CORDIC_ITERS];

endmodule
